FILE: hdl/rwcd_pkg.sv
// Shared types, constants and the channel decode for the readout word channel demux.
package rwcd_pkg;

  localparam int CHANNELS    = 24;
  localparam int CH_W        = $clog2(CHANNELS);
  localparam int MAX_SAMPLES = 20;
  localparam int CNT_W       = 5;

  typedef logic [CH_W-1:0]  chan_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Sub-channel code that drops the word, and the good valid/error code
  localparam logic [1:0] SUB_DROP = 2'b11;
  localparam logic [1:0] ERDV_OK  = 2'b01;

  localparam cnt_t MAX_COUNT = CNT_W'(MAX_SAMPLES);

  // One channel's entry in the state memory
  typedef struct packed {
    cnt_t tp_count;
    cnt_t daq_count;
    logic err;
  } entry_t;

  // Write port of the state memory
  typedef struct packed {
    logic   en;
    chan_t  addr;
    entry_t data;
  } mem_wr_t;

  // Item held in the update stage
  typedef struct packed {
    logic [15:0] word;
    logic        mode;
    logic        first;
    logic        drop;
    chan_t       ch;
  } item_t;

  // Result of the update stage
  typedef struct packed {
    logic        valid;
    logic        section;
    chan_t       channel;
    cnt_t        index;
    logic [9:0]  value;
    logic        err;
    cnt_t        count;
  } result_t;

  // Linear channel: fiber * 3 + sub-channel
  function automatic chan_t decode_channel(logic [4:0] code);
    logic [2:0] fiber;
    logic [1:0] sub;
    fiber = code[4:2];
    sub   = code[1:0];
    return ({2'b00, fiber} << 1) + {2'b00, fiber} + {3'b000, sub};
  endfunction

endpackage

FILE: hdl/rwcd_state_mem.sv
// Per-channel count and error memory with registered read, forwarding and valid bits.
module rwcd_state_mem (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  rwcd_pkg::chan_t  rd_addr,
  input  logic             clear,
  input  rwcd_pkg::mem_wr_t wr,
  output rwcd_pkg::entry_t rd_entry
);
  import rwcd_pkg::*;

  entry_t                mem [CHANNELS];
  entry_t                rd_data;
  logic                  rd_hit;
  logic [CHANNELS-1:0]   valid;
  logic                  fwd;

  // Write in this cycle to the entry being read
  assign fwd = wr.en && (wr.addr == rd_addr);

  // Memory array and read register
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data <= fwd ? wr.data : mem[rd_addr];
    end
  end

  // Valid bits: a clear at the start of an event wins over a write at the same edge
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (clear) begin
        valid <= '0;
      end else if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit <= !clear && (fwd || valid[rd_addr]);
      end
    end
  end

  // An entry not written since the last clear reads as zero
  assign rd_entry = rd_hit ? rd_data : '0;

endmodule

FILE: hdl/rwcd_update.sv
// Update stage: count and error checks, entry write-back and last-channel memory.
module rwcd_update (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  rwcd_pkg::item_t   s1,
  input  rwcd_pkg::entry_t  entry,
  output rwcd_pkg::mem_wr_t wr,
  output rwcd_pkg::result_t res
);
  import rwcd_pkg::*;

  chan_t      last_ch;
  logic       last_valid;
  logic [1:0] last_cap;

  logic       lv;
  logic [1:0] cap;
  logic [1:0] erdv;
  logic       bad;
  logic       tp_full;
  logic       daq_full;
  entry_t     new_entry;
  cnt_t       idx;

  assign cap      = s1.word[8:7];
  assign erdv     = s1.word[10:9];
  assign lv       = s1.first ? 1'b0 : last_valid;
  assign bad      = (erdv != ERDV_OK) ||
                    (lv && (last_ch == s1.ch) && (cap != (last_cap + 2'd1)));
  assign tp_full  = entry.tp_count >= MAX_COUNT;
  assign daq_full = entry.daq_count >= MAX_COUNT;

  // New entry and result
  always_comb begin
    new_entry   = entry;
    idx         = '0;
    res         = '0;
    res.section = s1.mode;
    res.channel = s1.ch;
    res.value   = s1.word[9:0];
    if (!s1.drop) begin
      if (!s1.mode) begin
        idx       = entry.tp_count;
        res.valid = !tp_full;
        res.err   = 1'b0;
        if (!tp_full) begin
          new_entry.tp_count = entry.tp_count + 1'b1;
        end
      end else begin
        idx           = entry.daq_count;
        new_entry.err = entry.err | bad | daq_full;
        res.valid     = !daq_full;
        res.err       = new_entry.err;
        if (!daq_full) begin
          new_entry.daq_count = entry.daq_count + 1'b1;
        end
      end
    end
    res.index = idx;
    res.count = idx + 1'b1;
  end

  assign wr.en   = fire && !s1.drop;
  assign wr.addr = s1.ch;
  assign wr.data = new_entry;

  // Last DAQ channel and capacitor id
  always_ff @(posedge clk) begin
    if (rst) begin
      last_valid <= 1'b0;
      last_ch    <= '0;
      last_cap   <= '0;
    end else if (fire) begin
      if (!s1.drop && s1.mode) begin
        last_valid <= 1'b1;
        last_ch    <= s1.ch;
        last_cap   <= cap;
      end else if (s1.first) begin
        last_valid <= 1'b0;
        last_ch    <= '0;
        last_cap   <= '0;
      end
    end
  end

endmodule

FILE: hdl/readout_word_channel_demux.sv
// Top level of the readout word channel demux: input stage, state memory, update, output register.
//
//  Channel   Handshake                    Payload
//  -------   --------------------------   ----------------------------------------------
//  input     word_valid / word_stall      word[15:0], mode, first_of_event
//  output    result_valid / result_stall  section, channel[4:0], sample_index[4:0],
//                                         sample_value[9:0], channel_error, sample_count[4:0]
//
//  One item per cycle unless stalled; result_valid is registered after the update stage.
//  The state memory read is registered at accept, the update and write-back follow at fire;
//  a write to the channel being read is forwarded into the read register.
//  Reset (rst, synchronous) empties the pipeline and clears all channel valid bits
//  and the last-channel memory; no clearing pass is needed.
//  A held result stalls the input only while the update stage is also full.
module readout_word_channel_demux (
  input  logic        clk,
  input  logic        rst,
  input  logic        word_valid,
  output logic        word_stall,
  input  logic [15:0] word,
  input  logic        mode,
  input  logic        first_of_event,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        section,
  output logic [4:0]  channel,
  output logic [4:0]  sample_index,
  output logic [9:0]  sample_value,
  output logic        channel_error,
  output logic [4:0]  sample_count
);
  import rwcd_pkg::*;

  logic    out_ready;
  logic    accept;
  logic    fire;
  logic    s1_valid;
  item_t   s1;
  item_t   in_item;
  entry_t  entry;
  mem_wr_t wr;
  result_t res;
  result_t out_reg;

  assign out_ready  = !result_valid || !result_stall;
  assign word_stall = s1_valid && !out_ready;
  assign accept     = word_valid && !word_stall;
  assign fire       = s1_valid && out_ready;

  // Decode of the incoming item
  always_comb begin
    in_item       = '0;
    in_item.word  = word;
    in_item.mode  = mode;
    in_item.first = first_of_event;
    in_item.drop  = word[12:11] == SUB_DROP;
    in_item.ch    = decode_channel(word[15:11]);
  end

  rwcd_state_mem u_mem (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept && !in_item.drop),
    .rd_addr  (in_item.ch),
    .clear    (accept && first_of_event),
    .wr       (wr),
    .rd_entry (entry)
  );

  // Update stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= in_item;
    end
  end

  rwcd_update u_update (
    .clk   (clk),
    .rst   (rst),
    .fire  (fire),
    .s1    (s1),
    .entry (entry),
    .wr    (wr),
    .res   (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_ready) begin
      result_valid <= fire && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.valid) begin
      out_reg <= res;
    end
  end

  assign section       = out_reg.section;
  assign channel       = out_reg.channel;
  assign sample_index  = out_reg.index;
  assign sample_value  = out_reg.value;
  assign channel_error = out_reg.err;
  assign sample_count  = out_reg.count;

  // Checks
  a_count_follows_index: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (sample_count == sample_index + 5'd1))
    else $error("sample_count does not follow sample_index");

  a_tp_no_error: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !section) |-> !channel_error)
    else $error("error flagged on a trigger primitive result");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (sample_index < MAX_COUNT))
    else $error("sample slot beyond the channel limit");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    word_stall |-> (s1_valid && result_valid && result_stall))
    else $error("input stalled with room in the pipeline");

  a_write_only_on_fire: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (s1_valid && out_ready))
    else $error("state memory written outside an update");

endmodule
